FILE: rtl/pas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pas_pkg
// Constants, codes and stage types of the pointer angle arcsine pipeline.
// ----------------------------------------------------------------------------
package pas_pkg;

   localparam int COORD_BITS = 10;
   localparam int FRAC_BITS  = 14;

   localparam int DELTA_BITS = COORD_BITS + 1;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int R2_BITS    = SQ_BITS + 1;
   localparam int REM_BITS   = SQ_BITS + 2;

   // sine ratio squared is formed in Q30
   localparam int Q_SHIFT    = 30;
   localparam int QUO_BITS   = Q_SHIFT + 1;

   localparam int RAD_BITS    = 32;
   localparam int SQRT_STEPS  = RAD_BITS / 2;
   localparam int ROOT_BITS   = 16;
   localparam int SREM_BITS   = 18;

   localparam int M_BITS = 15;
   localparam int P_BITS = 30;
   localparam logic [M_BITS-1:0] Q15_MAX = 15'h7fff;

   // reciprocals for exact division by 3, 5 and 21
   localparam int K3  = 31;
   localparam int K5  = 32;
   localparam int K21 = 35;
   localparam int R3_BITS  = 30;
   localparam int R5_BITS  = 30;
   localparam int R21_BITS = 31;
   localparam logic [R3_BITS-1:0]  R3  = R3_BITS'(((64'd1 << K3) + 64'd2) / 64'd3);
   localparam logic [R5_BITS-1:0]  R5  = R5_BITS'(((64'd1 << K5) + 64'd4) / 64'd5);
   localparam logic [R21_BITS-1:0] R21 = R21_BITS'(((64'd1 << K21) + 64'd20) / 64'd21);
   localparam int A_BITS = 28;
   localparam int B_BITS = 27;
   localparam int C_BITS = 26;

   localparam int T_BITS     = 32;
   localparam int ROUND_SH   = Q_SHIFT - FRAC_BITS;
   localparam logic [T_BITS-1:0] ROUND_HALF = T_BITS'(1) << (ROUND_SH - 1);
   localparam int ANGLE_BITS = 16;
   localparam logic [ANGLE_BITS-1:0] ANGLE_MAX = 16'h7fff;

   localparam int POLY_STAGES = 6;

   localparam int CSR_INDEX_BITS = 2;
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PIVOT_X = 2'd0,
      CSR_PIVOT_Y = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic                neg;
      logic                zero;
      logic [R2_BITS-1:0]  r2;
      logic [REM_BITS-1:0] rem;
      logic [QUO_BITS-1:0] quo;
   } div_stage_type;

   typedef struct packed {
      logic                 neg;
      logic                 zero;
      logic [RAD_BITS-1:0]  rad;
      logic [SREM_BITS-1:0] rem;
      logic [ROOT_BITS-1:0] root;
   } sqrt_stage_type;

   typedef struct packed {
      logic              neg;
      logic              zero;
      logic [M_BITS-1:0] m;
      logic [P_BITS-1:0] p2;
      logic [P_BITS-1:0] pn;
      logic [A_BITS-1:0] a;
      logic [B_BITS-1:0] b;
      logic [C_BITS-1:0] c;
      logic [T_BITS-1:0] t;
   } poly_stage_type;

endpackage
`default_nettype wire

FILE: rtl/pointer_angle_arcsine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pointer_angle_arcsine
// Pointer angle from a pivot: radius, sine ratio and a seventh order arcsine
// series, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req       in         req_valid/req_stall   req_point_x, req_point_y
//  rsp       out        rsp_valid/rsp_stall   rsp_angle, rsp_zero_radius
//  csr       in         csr_valid/csr_ready   csr_index, csr_wdata
//
//  one request per cycle unless the result stalls; 56 register stages:
//  2 front stages, 31 restoring divider stages (one quotient bit each),
//  16 square root stages (one root bit each), 6 series stages and the
//  output register
//  synchronous reset clears valid bits and loads the pivot defaults
//  a stalled result freezes the whole pipeline, req_stall follows it
// ----------------------------------------------------------------------------
module pointer_angle_arcsine
   import pas_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [COORD_BITS-1:0]         req_point_x,
   input  wire logic [COORD_BITS-1:0]         req_point_y,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic signed [ANGLE_BITS-1:0]  rsp_angle,
   output      logic                          rsp_zero_radius,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [COORD_BITS-1:0]         csr_wdata
);

   logic                  adv;
   logic [COORD_BITS-1:0] pivot_x_ff, pivot_y_ff;

   // front
   logic signed [DELTA_BITS-1:0] dx, dy;
   logic [DELTA_BITS-1:0]        adx_full, ady_full;
   logic                         s0_vld_ff, s0_neg_ff;
   logic [COORD_BITS-1:0]        s0_adx_ff, s0_ady_ff;
   logic [SQ_BITS-1:0]           dx2, dy2;

   div_stage_type  div_ff [0:QUO_BITS];
   div_stage_type  div_in [0:QUO_BITS];
   logic [QUO_BITS:0] div_vld_ff;

   sqrt_stage_type sq_ff [1:SQRT_STEPS];
   sqrt_stage_type sq_in [0:SQRT_STEPS];
   logic [SQRT_STEPS:1] sq_vld_ff;

   poly_stage_type pl_ff [1:POLY_STAGES];
   poly_stage_type pl_in [1:POLY_STAGES];
   logic [POLY_STAGES:1] pl_vld_ff;

   logic [2*M_BITS-1:0]           mm;
   logic [P_BITS+M_BITS-1:0]      prod3;
   logic [2*P_BITS-1:0]           prod5, prod7;
   logic [R3_BITS+P_BITS-2:0]     prod_a;
   logic [R5_BITS+P_BITS-2:0]     prod_b;
   logic [R21_BITS+P_BITS-1:0]    prod_c;
   logic [P_BITS+1:0]             x5_full;
   logic [P_BITS+3:0]             x21_full;
   logic [T_BITS-1:0]             rnd, mag_full;
   logic [ANGLE_BITS-1:0]         mag;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [ANGLE_BITS-1:0]  rsp_angle_ff, rsp_angle_in;
   logic                          rsp_zero_radius_ff, rsp_zero_radius_in;

   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type       r;
      logic                ge;
      logic [REM_BITS-1:0] sub;
      r   = s;
      ge  = s.rem >= REM_BITS'(s.r2);
      sub = s.rem - REM_BITS'(s.r2);
      r.rem = ge ? {sub[REM_BITS-2:0], 1'b0} : {s.rem[REM_BITS-2:0], 1'b0};
      r.quo = {s.quo[QUO_BITS-2:0], ge};
      return r;
   endfunction

   function automatic sqrt_stage_type sqrt_step(input sqrt_stage_type s);
      sqrt_stage_type       r;
      logic [SREM_BITS-1:0] remx, trial;
      logic                 ge;
      r     = s;
      remx  = {s.rem[SREM_BITS-3:0], s.rad[RAD_BITS-1 -: 2]};
      trial = {s.root, 2'b01};
      ge    = remx >= trial;
      r.rem  = ge ? remx - trial : remx;
      r.root = {s.root[ROOT_BITS-2:0], ge};
      r.rad  = {s.rad[RAD_BITS-3:0], 2'b00};
      return r;
   endfunction

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pivot_x_ff <= COORD_BITS'(621);
         pivot_y_ff <= COORD_BITS'(300);
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_PIVOT_X: pivot_x_ff <= csr_wdata;
            CSR_PIVOT_Y: pivot_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 0: offsets from the pivot
   always_comb begin
      dx = signed'({1'b0, req_point_x}) - signed'({1'b0, pivot_x_ff});
      dy = signed'({1'b0, req_point_y}) - signed'({1'b0, pivot_y_ff});
      adx_full = dx[DELTA_BITS-1] ? -dx : dx;
      ady_full = dy[DELTA_BITS-1] ? -dy : dy;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_neg_ff <= dx[DELTA_BITS-1];
         s0_adx_ff <= adx_full[COORD_BITS-1:0];
         s0_ady_ff <= ady_full[COORD_BITS-1:0];
      end
   end

   // stage 1: squares and radius squared, then the divider chain
   always_comb begin
      dx2 = s0_adx_ff * s0_adx_ff;
      dy2 = s0_ady_ff * s0_ady_ff;
      div_in[0].neg  = s0_neg_ff;
      div_in[0].r2   = R2_BITS'(dx2) + R2_BITS'(dy2);
      div_in[0].zero = (div_in[0].r2 == '0);
      div_in[0].rem  = REM_BITS'(dx2);
      div_in[0].quo  = '0;
      for (int i = 1; i <= QUO_BITS; i++) begin
         div_in[i] = div_step(div_ff[i-1]);
      end
   end

   // square root chain on the Q30 quotient
   always_comb begin
      sq_in[0].neg  = div_ff[QUO_BITS].neg;
      sq_in[0].zero = div_ff[QUO_BITS].zero;
      sq_in[0].rad  = RAD_BITS'(div_ff[QUO_BITS].quo);
      sq_in[0].rem  = '0;
      sq_in[0].root = '0;
      sq_in[1]      = sqrt_step(sq_in[0]);
      for (int i = 2; i <= SQRT_STEPS; i++) begin
         sq_in[i] = sqrt_step(sq_ff[i-1]);
      end
   end

   // series: at most one power multiply per stage, reciprocal divides alongside
   always_comb begin
      pl_in[1]      = '0;
      pl_in[1].neg  = sq_ff[SQRT_STEPS].neg;
      pl_in[1].zero = sq_ff[SQRT_STEPS].zero;
      // unit sine saturates just below one
      pl_in[1].m    = sq_ff[SQRT_STEPS].root[ROOT_BITS-1] ? Q15_MAX
                      : sq_ff[SQRT_STEPS].root[M_BITS-1:0];
      mm            = pl_in[1].m * pl_in[1].m;
      pl_in[1].p2   = mm;

      pl_in[2]    = pl_ff[1];
      prod3       = pl_ff[1].p2 * pl_ff[1].m;
      pl_in[2].pn = prod3[P_BITS+M_BITS-1:M_BITS];

      pl_in[3]    = pl_ff[2];
      prod5       = pl_ff[2].pn * pl_ff[2].p2;
      pl_in[3].pn = prod5[2*P_BITS-1:P_BITS];
      prod_a      = pl_ff[2].pn[P_BITS-1:1] * R3;
      pl_in[3].a  = prod_a[R3_BITS+P_BITS-2:K3];

      pl_in[4]    = pl_ff[3];
      prod7       = pl_ff[3].pn * pl_ff[3].p2;
      pl_in[4].pn = prod7[2*P_BITS-1:P_BITS];
      x5_full     = {2'b00, pl_ff[3].pn} + {1'b0, pl_ff[3].pn, 1'b0};
      prod_b      = x5_full[P_BITS+1:3] * R5;
      pl_in[4].b  = prod_b[R5_BITS+P_BITS-2:K5];

      pl_in[5]    = pl_ff[4];
      x21_full    = {pl_ff[4].pn, 4'b0000} - {4'b0000, pl_ff[4].pn};
      prod_c      = x21_full[P_BITS+3:4] * R21;
      pl_in[5].c  = prod_c[R21_BITS+P_BITS-1:K21];

      pl_in[6]    = pl_ff[5];
      pl_in[6].t  = T_BITS'({pl_ff[5].m, 15'b0}) + T_BITS'(pl_ff[5].a)
                    + T_BITS'(pl_ff[5].b) + T_BITS'(pl_ff[5].c);
   end

   // output: round half up, saturate, sign
   always_comb begin
      rnd      = pl_ff[POLY_STAGES].t + ROUND_HALF;
      mag_full = rnd >> ROUND_SH;
      mag      = (mag_full > T_BITS'(ANGLE_MAX)) ? ANGLE_MAX : mag_full[ANGLE_BITS-1:0];
      rsp_valid_in       = pl_vld_ff[POLY_STAGES];
      rsp_zero_radius_in = pl_ff[POLY_STAGES].zero;
      if (pl_ff[POLY_STAGES].zero) begin
         rsp_angle_in = '0;
      end else if (pl_ff[POLY_STAGES].neg) begin
         rsp_angle_in = -signed'(mag);
      end else begin
         rsp_angle_in = signed'(mag);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= QUO_BITS; i++) begin
            div_ff[i] <= div_in[i];
         end
         for (int i = 1; i <= SQRT_STEPS; i++) begin
            sq_ff[i] <= sq_in[i];
         end
         for (int i = 1; i <= POLY_STAGES; i++) begin
            pl_ff[i] <= pl_in[i];
         end
         rsp_angle_ff       <= rsp_angle_in;
         rsp_zero_radius_ff <= rsp_zero_radius_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff    <= 1'b0;
         div_vld_ff   <= '0;
         sq_vld_ff    <= '0;
         pl_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff    <= req_valid;
         div_vld_ff   <= {div_vld_ff[QUO_BITS-1:0], s0_vld_ff};
         sq_vld_ff    <= {sq_vld_ff[SQRT_STEPS-1:1], div_vld_ff[QUO_BITS]};
         pl_vld_ff    <= {pl_vld_ff[POLY_STAGES-1:1], sq_vld_ff[SQRT_STEPS]};
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_angle       = rsp_angle_ff;
   assign rsp_zero_radius = rsp_zero_radius_ff;

   // zero radius always comes with a zero angle
   a_zero_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_radius |-> rsp_angle == '0)
      else $error("zero radius with non-zero angle");

   // saturation keeps the most negative code out
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle != signed'({1'b1, {(ANGLE_BITS-1){1'b0}}}))
      else $error("angle outside saturation range");

   // a held result blocks new requests
   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while result held");

   // a stalled pipeline does not move its first stage
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(s0_vld_ff))
      else $error("front stage moved under stall");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule
`default_nettype wire

FILE: test/angle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_checker
// Watches the request, result and register channels of the pointer angle
// block, predicts each angle from the pivot it holds and compares results
// in order of arrival.
// ----------------------------------------------------------------------------
module angle_checker
   import pas_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic [COORD_BITS-1:0]         req_point_x,
   input  wire logic [COORD_BITS-1:0]         req_point_y,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic signed [ANGLE_BITS-1:0]  rsp_angle,
   input  wire logic                          rsp_zero_radius,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [COORD_BITS-1:0]         csr_wdata,
   output int                                 fail_count,
   output int                                 angles_pending
);

   typedef struct packed {
      logic signed [ANGLE_BITS-1:0] angle;
      logic                         zero_radius;
   } angle_result_type;

   angle_result_type       expected_angles[$];
   logic [COORD_BITS-1:0]  centre_x;
   logic [COORD_BITS-1:0]  centre_y;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v   = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic angle_result_type pointer_angle(logic [COORD_BITS-1:0] px,
                                                      logic [COORD_BITS-1:0] py);
      angle_result_type r;
      longint          dx, dy;
      bit              neg;
      longint unsigned adx, ady, dx2, r2, m, p2, p3, p5, p7, t, mag;
      dx  = longint'(px) - longint'(centre_x);
      dy  = longint'(py) - longint'(centre_y);
      neg = dx < 0;
      adx = neg ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      dx2 = adx * adx;
      r2  = dx2 + ady * ady;
      if (r2 == 0) begin
         r.angle       = '0;
         r.zero_radius = 1'b1;
         return r;
      end
      m = int_sqrt((dx2 << 30) / r2);
      // a pure horizontal offset gives a sine of one, held just below
      if (m > 32767) m = 32767;
      p2  = m * m;
      p3  = (p2 * m) >> 15;
      p5  = (p3 * p2) >> 30;
      p7  = (p5 * p2) >> 30;
      t   = (m << 15) + p3 / 6 + (3 * p5) / 40 + (15 * p7) / 336;
      mag = (t + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      if (mag > 32767) mag = 32767;
      r.angle       = neg ? -ANGLE_BITS'(mag) : ANGLE_BITS'(mag);
      r.zero_radius = 1'b0;
      return r;
   endfunction

   assign angles_pending = expected_angles.size();

   always @(posedge clock) begin
      angle_result_type want;
      int               errors;
      errors = 0;
      if (reset) begin
         centre_x   <= 10'd621;
         centre_y   <= 10'd300;
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PIVOT_X) centre_x <= csr_wdata;
            else if (csr_index == CSR_PIVOT_Y) centre_y <= csr_wdata;
         end
         if (req_valid && !req_stall)
            expected_angles.push_back(pointer_angle(req_point_x, req_point_y));
         if (rsp_valid && !rsp_stall) begin
            if (expected_angles.size() == 0) begin
               $display("%0t: result with nothing expected: angle %0d zero %0b",
                        $time, rsp_angle, rsp_zero_radius);
               errors = errors + 1;
            end else begin
               want = expected_angles.pop_front();
               if (want.angle !== rsp_angle) begin
                  $display("%0t: angle expected %0d actual %0d",
                           $time, want.angle, rsp_angle);
                  errors = errors + 1;
               end
               if (want.zero_radius !== rsp_zero_radius) begin
                  $display("%0t: zero_radius expected %0b actual %0b",
                           $time, want.zero_radius, rsp_zero_radius);
                  errors = errors + 1;
               end
            end
         end
         fail_count <= fail_count + errors;
      end
   end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pointer positions and pivot writes into the arcsine pipeline with
// random gaps and result stalls; the checker beside it judges every angle.
// ----------------------------------------------------------------------------
module testbench
   import pas_pkg::*;
();

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_3 = 2'd3;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 400000;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [COORD_BITS-1:0]        req_point_x;
   logic [COORD_BITS-1:0]        req_point_y;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic signed [ANGLE_BITS-1:0] rsp_angle;
   logic                         rsp_zero_radius;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [CSR_INDEX_BITS-1:0]    csr_index;
   logic [COORD_BITS-1:0]        csr_wdata;
   int                           fail_count;
   int                           angles_pending;
   int                           cycle_count;
   bit                           no_gaps;
   logic [COORD_BITS-1:0]        centre_x;
   logic [COORD_BITS-1:0]        centre_y;

   pointer_angle_arcsine i_dut (.*);

   angle_checker i_checker (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   always @(posedge clock) begin
      rsp_stall   <= no_gaps ? 1'b0 : ($urandom_range(99) < 28);
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_point(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
      while (!no_gaps && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      // stall is settled mid-cycle, ahead of the edge that samples it
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (angles_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [COORD_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_PIVOT_X) centre_x = value;
      else if (idx == CSR_PIVOT_Y) centre_y = value;
   endtask

   task automatic set_pivot(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
      write_reg(CSR_PIVOT_X, px);
      write_reg(CSR_PIVOT_Y, py);
   endtask

   function automatic logic [COORD_BITS-1:0] near(logic [COORD_BITS-1:0] c);
      int v;
      v = int'(c) + $urandom_range(6) - 3;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return v[COORD_BITS-1:0];
   endfunction

   task automatic random_points(int count);
      logic [COORD_BITS-1:0] px, py;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(9))
            0: begin px = centre_x; py = centre_y; end
            1: begin px = COORD_BITS'($urandom); py = centre_y; end
            2: begin px = centre_x; py = COORD_BITS'($urandom); end
            3, 4: begin px = near(centre_x); py = near(centre_y); end
            default: begin px = COORD_BITS'($urandom); py = COORD_BITS'($urandom); end
         endcase
         send_point(px, py);
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_point_x = '0;
      req_point_y = '0;
      rsp_stall   = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = CSR_PIVOT_X;
      csr_wdata   = '0;
      cycle_count = 0;
      no_gaps     = 1'b0;
      centre_x    = 10'd621;
      centre_y    = 10'd300;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default pivot: coincident point, horizontal both ways, vertical, corners, x offsets of one
      send_point(10'd621, 10'd300);
      send_point(10'd1023, 10'd300);
      send_point(10'd0, 10'd300);
      send_point(10'd621, 10'd0);
      send_point(10'd621, 10'd1023);
      send_point(10'd0, 10'd0);
      send_point(10'd1023, 10'd1023);
      send_point(10'd0, 10'd1023);
      send_point(10'd1023, 10'd0);
      send_point(10'd622, 10'd1023);
      send_point(10'd620, 10'd299);
      drain();
      // writes to unused indexes must leave the pivot alone
      write_reg(CSR_SPARE_2, 10'd5);
      write_reg(CSR_SPARE_3, 10'd1023);
      send_point(10'd621, 10'd300);
      send_point(10'd0, 10'd301);
      drain();
      set_pivot(10'd0, 10'd0);
      send_point(10'd0, 10'd0);
      send_point(10'd1023, 10'd0);
      send_point(10'd1023, 10'd1023);
      send_point(10'd1, 10'd1023);
      drain();
      set_pivot(10'd1023, 10'd1023);
      send_point(10'd1023, 10'd1023);
      send_point(10'd0, 10'd1023);
      send_point(10'd0, 10'd0);
      send_point(10'd1022, 10'd0);
      drain();

      set_pivot(10'd621, 10'd300);
      random_points(300);
      drain();
      set_pivot(10'd0, 10'd1023);
      random_points(150);
      // hold off until the pipeline has handed back everything
      req_valid <= 1'b0;
      @(posedge clock);
      while (angles_pending != 0) @(posedge clock);
      random_points(150);
      drain();
      no_gaps = 1'b1;
      set_pivot(10'd1023, 10'd0);
      random_points(300);
      drain();
      no_gaps = 1'b0;
      for (int phase = 0; phase < 3; phase++) begin
         set_pivot(COORD_BITS'($urandom), COORD_BITS'($urandom));
         random_points(280);
         drain();
      end

      if (fail_count == 0 && angles_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/pas_pkg.sv
rtl/pointer_angle_arcsine.sv
test/angle_checker.sv
test/testbench.sv
